/* rtl/assert_macros.svh */
// assertion macros used by the translator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/tlbpt_pkg.sv */
// shared widths, defaults and helpers of the tlb page table translator
package tlbpt_pkg;

   // fixed field widths
   localparam int ADDR_WIDTH      = 20;
   localparam int FRAME_OUT_WIDTH = 10;
   localparam int COUNT_WIDTH     = 32;

   // parameter defaults
   localparam int TLB_ENTRIES_DEF  = 16;
   localparam int PAGE_COUNT_DEF   = 1024;
   localparam int OFFSET_WIDTH_DEF = 10;

   // saturating counter step
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] value,
                                                      input logic                   step);
      logic [COUNT_WIDTH-1:0] result;
      result = value;
      if (step && (value != '1)) begin
         result = value + 1'b1;
      end
      return result;
   endfunction

endpackage

/* rtl/tlbpt_if.sv */
// request and response channel interfaces of the translator

// request channel: one logical address per word
interface tlbpt_req_if;
   logic                              valid;
   logic                              ready;
   logic [tlbpt_pkg::ADDR_WIDTH-1:0] virt_addr;

   modport source (output valid, output virt_addr, input ready);
   modport sink   (input valid, input virt_addr, output ready);
endinterface

// response channel: one translation result per word
interface tlbpt_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [tlbpt_pkg::ADDR_WIDTH-1:0]      phys_addr;
   logic [tlbpt_pkg::FRAME_OUT_WIDTH-1:0] frame_number;
   logic                                   tlb_hit;
   logic                                   page_fault;
   logic [tlbpt_pkg::COUNT_WIDTH-1:0]     translation_count;
   logic [tlbpt_pkg::COUNT_WIDTH-1:0]     hit_count;
   logic [tlbpt_pkg::COUNT_WIDTH-1:0]     fault_count;

   modport source (output valid, output phys_addr, output frame_number,
                   output tlb_hit, output page_fault, output translation_count,
                   output hit_count, output fault_count, input ready);
   modport sink   (input valid, input phys_addr, input frame_number,
                   input tlb_hit, input page_fault, input translation_count,
                   input hit_count, input fault_count, output ready);
endinterface

/* rtl/tlb_page_table_translator.sv */
// A request word is registered in stage 1, in stage 2 and in the output register on its way to its response word.
// Throughput: one word per cycle; the whole pipeline stalls only while a response waits.
// Stages: quotient register, page table read (one registered memory port), tlb compare.
// Reset (synchronous) empties the pipeline, the tlb and the counters, then a clearing pass
// over all PAGE_COUNT entries (1024 by default) sweeps the page table; req_ready stays low meanwhile.
`include "assert_macros.svh"

module tlb_page_table_translator #(
   parameter int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_COUNT   = tlbpt_pkg::PAGE_COUNT_DEF,
   parameter int OFFSET_WIDTH = tlbpt_pkg::OFFSET_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   tlbpt_req_if.sink     req_ch,
   tlbpt_rsp_if.source   rsp_ch
);

   localparam int ADDR_W    = tlbpt_pkg::ADDR_WIDTH;
   localparam int CNT_W     = tlbpt_pkg::COUNT_WIDTH;
   localparam int RAW_W     = ADDR_W - OFFSET_WIDTH;
   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam int SLOT_W    = $clog2(TLB_ENTRIES);
   localparam int NFF_W     = $clog2(PAGE_COUNT + 1);
   localparam int MOD_SHIFT = RAW_W + PAGE_W;
   localparam int RECIP_W   = RAW_W + 1;
   localparam int PROD_W    = RAW_W + RECIP_W;
   localparam int REM_W     = RAW_W + NFF_W;
   localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((64'd1 << MOD_SHIFT) / PAGE_COUNT);

   // pipeline control
   logic advance;
   logic req_ready;
   logic req_accept;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [PAGE_W-1:0] clr_idx_ff, clr_idx_in;

   // stage 1: raw page number, quotient estimate, offset
   logic                    s1_valid_ff, s1_valid_in;
   logic [RAW_W-1:0]        s1_raw_ff, s1_raw_in;
   logic [RAW_W-1:0]        s1_quot_ff, s1_quot_in;
   logic [OFFSET_WIDTH-1:0] s1_offset_ff, s1_offset_in;
   logic [PROD_W-1:0]       quot_prod;
   logic [REM_W-1:0]        quot_times_count;
   logic [REM_W-1:0]        rem_est;
   logic [PAGE_W-1:0]       s1_page;

   // stage 2: page number, offset, page table word
   logic                    s2_valid_ff, s2_valid_in;
   logic [PAGE_W-1:0]       s2_page_ff, s2_page_in;
   logic [OFFSET_WIDTH-1:0] s2_offset_ff, s2_offset_in;
   logic [PAGE_W:0]         pt_rd_ff;
   logic                    s2_fire;
   logic                    s2_hit;
   logic                    s2_fault;
   logic [PAGE_W-1:0]       s2_frame;
   logic [PAGE_W-1:0]       tlb_frame_sel;
   logic [TLB_ENTRIES-1:0]  tlb_match;

   // page table memory: mapped flag over frame
   logic [PAGE_W:0]         pt_mem [PAGE_COUNT];
   logic                    pt_we;
   logic [PAGE_W-1:0]       pt_waddr;
   logic [PAGE_W:0]         pt_wdata;

   // tlb entries
   logic [PAGE_W-1:0]       tlb_tag_ff   [TLB_ENTRIES];
   logic [PAGE_W-1:0]       tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]  tlb_valid_ff;
   logic [SLOT_W-1:0]       victim_ff, victim_in;
   logic                    tlb_insert;

   // frame allocator and counters
   logic [NFF_W-1:0]        nff_ff, nff_in;
   logic [CNT_W-1:0]        trans_ff, trans_in;
   logic [CNT_W-1:0]        hits_ff, hits_in;
   logic [CNT_W-1:0]        faults_ff, faults_in;

   // output register
   logic                    out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]       out_phys_ff, out_phys_in;
   logic [tlbpt_pkg::FRAME_OUT_WIDTH-1:0] out_frame_ff, out_frame_in;
   logic                    out_hit_ff, out_hit_in;
   logic                    out_fault_ff, out_fault_in;

   // the whole pipeline moves when the output word is free or being taken
   assign advance    = !out_valid_ff || rsp_ch.ready;
   assign req_ready  = advance && !clearing_ff;
   assign req_accept = req_ch.valid && req_ready;
   assign s2_fire    = advance && s2_valid_ff;

   assign req_ch.ready = req_ready;

   // clearing pass sweeps the page table after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == PAGE_W'(PAGE_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // quotient estimate of the raw page number by the page count
   assign quot_prod = PROD_W'(req_ch.virt_addr[ADDR_W-1:OFFSET_WIDTH])
                      * PROD_W'(MOD_RECIP);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_raw_in    = s1_raw_ff;
      s1_quot_in   = s1_quot_ff;
      s1_offset_in = s1_offset_ff;
      if (advance) begin
         s1_valid_in  = req_accept;
         s1_raw_in    = req_ch.virt_addr[ADDR_W-1:OFFSET_WIDTH];
         s1_quot_in   = RAW_W'(quot_prod >> MOD_SHIFT);
         s1_offset_in = req_ch.virt_addr[OFFSET_WIDTH-1:0];
      end
   end

   // remainder with one correction step gives the page index
   assign quot_times_count = REM_W'(s1_quot_ff) * REM_W'(PAGE_COUNT);
   assign rem_est          = REM_W'(s1_raw_ff) - quot_times_count;

   always_comb begin
      s1_page = PAGE_W'(rem_est);
      if (rem_est >= REM_W'(PAGE_COUNT)) begin
         s1_page = PAGE_W'(rem_est - REM_W'(PAGE_COUNT));
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_page_in   = s2_page_ff;
      s2_offset_in = s2_offset_ff;
      if (advance) begin
         s2_valid_in  = s1_valid_ff;
         s2_page_in   = s1_page;
         s2_offset_in = s1_offset_ff;
      end
   end

   // tlb compare across all entries
   always_comb begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tlb_match[i] = tlb_valid_ff[i] && (tlb_tag_ff[i] == s2_page_ff);
      end
   end

   // lowest matching entry wins
   always_comb begin
      tlb_frame_sel = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_match[i]) begin
            tlb_frame_sel = tlb_frame_ff[i];
         end
      end
   end

   // frame source: tlb, then page table, else a fresh frame
   always_comb begin
      s2_hit   = |tlb_match;
      s2_fault = 1'b0;
      priority if (s2_hit) begin
         s2_frame = tlb_frame_sel;
      end else if (pt_rd_ff[PAGE_W]) begin
         s2_frame = pt_rd_ff[PAGE_W-1:0];
      end else begin
         s2_frame = nff_ff[PAGE_W-1:0];
         s2_fault = 1'b1;
      end
   end

   // state updates for a word leaving stage 2
   assign tlb_insert = s2_fire && !s2_hit;

   always_comb begin
      victim_in = victim_ff;
      if (tlb_insert) begin
         victim_in = (victim_ff == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : victim_ff + 1'b1;
      end
   end

   always_comb begin
      nff_in    = nff_ff;
      trans_in  = trans_ff;
      hits_in   = hits_ff;
      faults_in = faults_ff;
      if (s2_fire) begin
         nff_in    = nff_ff + NFF_W'(s2_fault);
         trans_in  = tlbpt_pkg::sat_inc(trans_ff, 1'b1);
         hits_in   = tlbpt_pkg::sat_inc(hits_ff, s2_hit);
         faults_in = tlbpt_pkg::sat_inc(faults_ff, s2_fault);
      end
   end

   // page table write port: clearing pass or a newly mapped page
   always_comb begin
      pt_we    = 1'b0;
      pt_waddr = s2_page_ff;
      pt_wdata = {1'b1, s2_frame};
      if (clearing_ff) begin
         pt_we    = 1'b1;
         pt_waddr = clr_idx_ff;
         pt_wdata = '0;
      end else if (s2_fire && s2_fault) begin
         pt_we = 1'b1;
      end
   end

   // result word
   always_comb begin
      out_valid_in = out_valid_ff;
      out_phys_in  = out_phys_ff;
      out_frame_in = out_frame_ff;
      out_hit_in   = out_hit_ff;
      out_fault_in = out_fault_ff;
      if (advance) begin
         out_valid_in = s2_valid_ff;
         out_phys_in  = (ADDR_W'(s2_frame) << OFFSET_WIDTH) | ADDR_W'(s2_offset_ff);
         out_frame_in = tlbpt_pkg::FRAME_OUT_WIDTH'(s2_frame);
         out_hit_in   = s2_hit;
         out_fault_in = s2_fault;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tlb_valid_ff <= '0;
         victim_ff    <= '0;
         nff_ff       <= '0;
         trans_ff     <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         victim_ff    <= victim_in;
         nff_ff       <= nff_in;
         trans_ff     <= trans_in;
         hits_ff      <= hits_in;
         faults_ff    <= faults_in;
         if (tlb_insert) begin
            tlb_valid_ff[victim_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_raw_ff    <= s1_raw_in;
      s1_quot_ff   <= s1_quot_in;
      s1_offset_ff <= s1_offset_in;
      s2_page_ff   <= s2_page_in;
      s2_offset_ff <= s2_offset_in;
      out_phys_ff  <= out_phys_in;
      out_frame_ff <= out_frame_in;
      out_hit_ff   <= out_hit_in;
      out_fault_ff <= out_fault_in;
      if (tlb_insert) begin
         tlb_tag_ff[victim_ff]   <= s2_page_ff;
         tlb_frame_ff[victim_ff] <= s2_frame;
      end
   end

   // page table memory with registered read
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pt_rd_ff <= pt_mem[s1_page];
      end
   end

   // response channel
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.phys_addr         = out_phys_ff;
   assign rsp_ch.frame_number      = out_frame_ff;
   assign rsp_ch.tlb_hit           = out_hit_ff;
   assign rsp_ch.page_fault        = out_fault_ff;
   assign rsp_ch.translation_count = trans_ff;
   assign rsp_ch.hit_count         = hits_ff;
   assign rsp_ch.fault_count       = faults_ff;

   // checks on tlb contents, frame supply and pipeline state
   `ASSERT_IMP(a_tlb_tags_unique, clock, reset, s2_valid_ff, $onehot0(tlb_match))
   `ASSERT_ALWAYS(a_free_frame_bound, clock, reset, nff_ff <= NFF_W'(PAGE_COUNT))
   `ASSERT_IMP(a_clear_pipe_empty, clock, reset, clearing_ff, !s1_valid_ff && !s2_valid_ff && !out_valid_ff)
   `ASSERT_NEXT(a_fault_takes_frame, clock, reset, s2_fire && s2_fault, nff_ff == $past(nff_ff) + 1'b1)
   `ASSERT_IMP(a_hits_within_total, clock, reset, out_valid_ff, hits_ff <= trans_ff)

endmodule
